[rtl/core/pstv_pkg.sv]
`default_nettype none
package pstv_pkg;

  localparam int NAME_CHARS_DEF = 8;
  localparam int POS_W          = 4;
  localparam int CHAR_W         = 8;
  localparam int CNT_W          = 4;
  localparam int DISP_CHARS     = 8;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 72;
  localparam int CFG_W          = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd4;
  localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

  typedef struct packed {
    logic              pos_ok;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } pstv_item_t;

endpackage
`default_nettype wire

[rtl/core/pstv_front.sv]
`default_nettype none
module pstv_front
  import pstv_pkg::*;
#(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 push,
  output pstv_item_t           push_item,
  input  wire logic            queue_full
);

  logic       v_r, v_nxt;
  pstv_item_t item_r, item_nxt;
  logic       take;

  assign push      = v_r && !queue_full;
  assign in_tready = !v_r || !queue_full;
  assign take      = in_tvalid && in_tready;
  assign push_item = item_r;

  always_comb begin
    v_nxt    = v_r;
    item_nxt = item_r;
    if (push) begin
      v_nxt = 1'b0;
    end
    if (take) begin
      v_nxt           = 1'b1;
      item_nxt.pos    = in_tdata[POS_W-1:0];
      item_nxt.ch     = in_tdata[POS_W+CHAR_W-1:POS_W];
      item_nxt.pos_ok = ({1'b0, in_tdata[POS_W-1:0]} < (POS_W+1)'(NAME_CHARS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    item_r <= item_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/pstv_queue.sv]
`default_nettype none
module pstv_queue
  import pstv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire pstv_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            q_valid,
  output pstv_item_t      q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  pstv_item_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pstv_back.sv]
`default_nettype none
module pstv_back
  import pstv_pkg::*;
#(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire pstv_item_t       q_item,
  output logic                  pop,
  input  wire logic             cfg_tvalid,
  output logic                  cfg_tready,
  input  wire logic [CFG_W-1:0] cfg_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int IDX_W = $clog2(NAME_CHARS);

  logic [CHAR_W-1:0] likely_r  [NAME_CHARS];
  logic [CHAR_W-1:0] alt_r     [NAME_CHARS];
  logic [CNT_W-1:0]  hit_r     [NAME_CHARS];
  logic [CHAR_W-1:0] disp_r    [NAME_CHARS];
  logic [CHAR_W-1:0] likely_nxt[NAME_CHARS];
  logic [CHAR_W-1:0] alt_nxt   [NAME_CHARS];
  logic [CNT_W-1:0]  hit_nxt   [NAME_CHARS];
  logic [CHAR_W-1:0] disp_nxt  [NAME_CHARS];

  logic [CNT_W-1:0]  limit_r;
  logic              out_v_r, out_v_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic [IDX_W-1:0]  idx;
  logic [CHAR_W-1:0] cur_lk, cur_al, new_lk, new_al;
  logic [CNT_W-1:0]  cur_hc, new_hc;
  logic [CNT_W:0]    lim_inc;
  logic              change, complete, differs;
  logic [CHAR_W*DISP_CHARS-1:0] disp_word;

  assign pop        = q_valid && (!out_v_r || out_tready);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;

  assign idx     = q_item.pos[IDX_W-1:0];
  assign cur_lk  = likely_r[idx];
  assign cur_al  = alt_r[idx];
  assign cur_hc  = hit_r[idx];
  assign lim_inc = {1'b0, limit_r} + 1'b1;

  // per-position candidate update
  always_comb begin
    new_lk = cur_lk;
    new_al = cur_al;
    new_hc = cur_hc;
    change = 1'b0;
    if (q_item.ch == cur_lk) begin
      if (cur_hc < limit_r) begin
        new_hc = cur_hc + 1'b1;
      end else begin
        new_hc = limit_r;
        new_al = q_item.ch;
      end
    end else if (q_item.ch == cur_al) begin
      if (cur_hc >= limit_r) begin
        change = 1'b1;
        new_hc = lim_inc[CNT_W] ? CNT_MAX : lim_inc[CNT_W-1:0];
      end else begin
        new_hc = limit_r;
      end
      new_al = cur_lk;
      new_lk = q_item.ch;
    end else if (cur_hc == '0) begin
      new_lk = q_item.ch;
      new_hc = CNT_W'(1);
    end else begin
      new_al = q_item.ch;
    end
  end

  // knock-down, completion check and display load
  always_comb begin
    complete = 1'b1;
    differs  = 1'b0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (POS_W'(k) == q_item.pos) begin
        likely_nxt[k] = new_lk;
        alt_nxt[k]    = new_al;
        hit_nxt[k]    = new_hc;
      end else begin
        likely_nxt[k] = likely_r[k];
        alt_nxt[k]    = alt_r[k];
        hit_nxt[k]    = hit_r[k];
      end
      if (change && (hit_nxt[k] > CNT_W'(1))) begin
        hit_nxt[k] = hit_nxt[k] - 1'b1;
      end
      if (hit_nxt[k] < limit_r) begin
        complete = 1'b0;
      end
    end
    for (int k = 0; k < NAME_CHARS; k++) begin
      disp_nxt[k] = disp_r[k];
      if (complete) begin
        if (disp_r[k] != likely_nxt[k]) begin
          differs = 1'b1;
        end
        disp_nxt[k] = likely_nxt[k];
      end
    end
  end

  // display word after this word, shown in the result
  always_comb begin
    disp_word = '0;
    for (int k = 0; k < DISP_CHARS; k++) begin
      if (k < NAME_CHARS) begin
        if (q_item.pos_ok) begin
          disp_word[k*CHAR_W +: CHAR_W] = disp_nxt[k];
        end else begin
          disp_word[k*CHAR_W +: CHAR_W] = disp_r[k];
        end
      end
    end
  end

  always_comb begin
    out_v_nxt     = out_v_r;
    out_tdata_nxt = out_tdata_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (pop) begin
      out_v_nxt     = 1'b1;
      out_tdata_nxt = '0;
      out_tdata_nxt[3 +: CHAR_W*DISP_CHARS] = disp_word;
      if (q_item.pos_ok) begin
        out_tdata_nxt[0] = complete;
        out_tdata_nxt[1] = differs;
        out_tdata_nxt[2] = change;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      limit_r <= LIMIT_RESET;
      for (int k = 0; k < NAME_CHARS; k++) begin
        likely_r[k] <= '0;
        alt_r[k]    <= '0;
        hit_r[k]    <= '0;
        disp_r[k]   <= '0;
      end
    end else begin
      out_v_r <= out_v_nxt;
      if (cfg_tvalid && cfg_tready) begin
        limit_r <= cfg_tdata[CNT_W-1:0];
      end
      if (pop && q_item.pos_ok) begin
        for (int k = 0; k < NAME_CHARS; k++) begin
          likely_r[k] <= likely_nxt[k];
          alt_r[k]    <= alt_nxt[k];
          hit_r[k]    <= hit_nxt[k];
          disp_r[k]   <= disp_nxt[k];
        end
      end
    end
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/ps_text_validator.sv]
// channel   dir   handshake              payload
// in        in    in_tvalid/in_tready    in_tdata[15:0]
// out       out   out_tvalid/out_tready  out_tdata[71:0]
// cfg       in    cfg_tvalid/cfg_tready  cfg_tdata[7:0], limit in low 4 bits
//
// one word per cycle sustained while out_tready stays high; a word passes the front
// register, the queue and the result register on its way to out_tdata
// the back stage updates all positions together from register arrays
// reset (rst_n low, synchronous) clears all counters, characters and display,
// and sets the limit to 4
// a two-entry queue lets front and back stall independently
`default_nettype none
module ps_text_validator
  import pstv_pkg::*;
#(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // char_position[3:0], char_value[11:4]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // text_complete[0], display_changed[1],
                                            // text_in_transition[2], display_text[66:3]
  input  wire logic             cfg_tvalid,
  output logic                  cfg_tready,
  input  wire logic [CFG_W-1:0] cfg_tdata   // validate_limit[3:0]
);

  logic       push, full, pop, q_valid;
  pstv_item_t push_item, q_item;

  pstv_front #(
    .NAME_CHARS(NAME_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_item (push_item),
    .queue_full(full)
  );

  pstv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  pstv_back #(
    .NAME_CHARS(NAME_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

[dv/pstv_checker.sv]
`default_nettype none
module pstv_checker
  import pstv_pkg::*;
#(
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // char_position[3:0], char_value[11:4]
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [OUT_W-1:0] out_tdata,  // text_complete[0], display_changed[1],
                                            // text_in_transition[2], display_text[66:3]
  input  wire logic             cfg_tvalid,
  input  wire logic             cfg_tready,
  input  wire logic [CFG_W-1:0] cfg_tdata,  // validate_limit[3:0]
  output int                    mismatches,
  output int                    words_pending
);

  typedef struct packed {
    logic                     complete;
    logic                     changed;
    logic                     transition;
    logic [DISP_CHARS*8-1:0]  text;
  } ps_result_t;

  logic [CHAR_W-1:0] likely    [NAME_CHARS];
  logic [CHAR_W-1:0] alternate [NAME_CHARS];
  logic [CNT_W-1:0]  hits      [NAME_CHARS];
  logic [CHAR_W-1:0] shown     [NAME_CHARS];
  logic [CNT_W-1:0]  limit;
  ps_result_t        result_q [$];
  int                errors = 0;

  function automatic ps_result_t validate_char(input logic [POS_W-1:0] pos,
                                               input logic [CHAR_W-1:0] ch);
    ps_result_t r;
    logic       all_confirmed;
    r = '0;
    if (pos < NAME_CHARS) begin
      if (ch == likely[pos]) begin
        if (hits[pos] < limit) begin
          hits[pos] = hits[pos] + 1'b1;
        end else begin
          hits[pos]      = limit;
          alternate[pos] = ch;
        end
      end else if (ch == alternate[pos]) begin
        if (hits[pos] >= limit) begin
          r.transition = 1'b1;
          hits[pos]    = (limit < CNT_MAX) ? limit + 1'b1 : CNT_MAX;
        end else begin
          hits[pos] = limit;
        end
        alternate[pos] = likely[pos];
        likely[pos]    = ch;
      end else if (hits[pos] == 0) begin
        likely[pos] = ch;
        hits[pos]   = CNT_W'(1);
      end else begin
        alternate[pos] = ch;
      end

      // knock down every count above one while the text is changing
      if (r.transition) begin
        foreach (hits[k]) begin
          if (hits[k] > 1) hits[k] = hits[k] - 1'b1;
        end
      end

      all_confirmed = 1'b1;
      foreach (hits[k]) begin
        if (hits[k] < limit) all_confirmed = 1'b0;
      end

      if (all_confirmed) begin
        r.complete = 1'b1;
        foreach (shown[k]) begin
          if (shown[k] != likely[k]) r.changed = 1'b1;
          shown[k] = likely[k];
        end
      end
    end
    for (int k = 0; k < DISP_CHARS; k++) begin
      if (k < NAME_CHARS) r.text[8*k +: 8] = shown[k];
    end
    return r;
  endfunction

  task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (errors < 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    ps_result_t want;
    ps_result_t got;
    if (!rst_n) begin
      foreach (likely[k]) begin
        likely[k]    = '0;
        alternate[k] = '0;
        hits[k]      = '0;
        shown[k]     = '0;
      end
      limit = LIMIT_RESET;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.complete   = out_tdata[0];
        got.changed    = out_tdata[1];
        got.transition = out_tdata[2];
        got.text       = out_tdata[3 +: DISP_CHARS*8];
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected word on out: %h", out_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          flag("text_complete", 64'(want.complete), 64'(got.complete));
          flag("display_changed", 64'(want.changed), 64'(got.changed));
          flag("text_in_transition", 64'(want.transition), 64'(got.transition));
          flag("display_text", want.text, got.text);
        end
      end
      if (cfg_tvalid && cfg_tready) limit = cfg_tdata[CNT_W-1:0];
      if (in_tvalid && in_tready) begin
        result_q.push_back(validate_char(in_tdata[POS_W-1:0], in_tdata[POS_W +: CHAR_W]));
      end
    end
    words_pending <= result_q.size();
    mismatches    <= errors;
  end

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb
  import pstv_pkg::*;
();

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [IN_W-1:0]   in_tdata   = '0;   // char_position[3:0], char_value[11:4]
  logic              in_tready;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // text_complete[0], display_changed[1],
                                        // text_in_transition[2], display_text[66:3]
  logic              cfg_tvalid = 1'b0;
  logic [CFG_W-1:0]  cfg_tdata  = '0;   // validate_limit[3:0]
  logic              cfg_tready;
  int                mismatches;
  int                words_pending;
  int                idle_pct   = 0;
  int                stall_pct  = 0;

  ps_text_validator #(.NAME_CHARS(NAME_CHARS_DEF)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  pstv_checker #(.NAME_CHARS(NAME_CHARS_DEF)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_tvalid    (cfg_tvalid),
    .cfg_tready    (cfg_tready),
    .cfg_tdata     (cfg_tdata),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_char(input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {4'b0000, ch, pos};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] lim);
    cfg_tdata  <= CFG_W'(lim);
    cfg_tvalid <= 1'b1;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
  endtask

  // mostly two competing station names swept in order, with some noise
  task automatic send_names(input int n_chars);
    logic [CHAR_W-1:0] name_a [NAME_CHARS_DEF];
    logic [CHAR_W-1:0] name_b [NAME_CHARS_DEF];
    logic [CHAR_W-1:0] held;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    int                sent;
    int                sweep;
    int                roll;
    foreach (name_a[k]) begin
      name_a[k] = CHAR_W'($urandom);
      name_b[k] = CHAR_W'($urandom);
    end
    sent  = 0;
    sweep = 0;
    while (sent < n_chars) begin
      if ($urandom_range(99) < 6) begin
        pos = POS_W'($urandom_range(15, NAME_CHARS_DEF));
        ch  = CHAR_W'($urandom);
      end else begin
        if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(NAME_CHARS_DEF - 1));
        else pos = POS_W'(sweep % NAME_CHARS_DEF);
        sweep++;
        roll = $urandom_range(99);
        if (roll < 72) ch = name_a[pos];
        else if (roll < 90) ch = name_b[pos];
        else ch = CHAR_W'($urandom);
        if ($urandom_range(149) == 0) begin
          foreach (name_a[k]) begin
            held      = name_a[k];
            name_a[k] = name_b[k];
            name_b[k] = held;
          end
        end
        if ($urandom_range(99) == 0) name_b[$urandom_range(NAME_CHARS_DEF - 1)] = CHAR_W'($urandom);
      end
      sent++;
      send_char(pos, ch);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] limits [8];
    int               idle_tab [4];
    int               stall_tab [4];
    limits    = '{4'd14, 4'd1, 4'd15, 4'd0, 4'd4, 4'd9, 4'd3, 4'd2};
    idle_tab  = '{0, 84, 0, 7};
    stall_tab = '{0, 0, 84, 7};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit, zero matches the cleared likely char
    send_char(4'd0, 8'h00);
    send_char(4'd1, 8'h41);
    drain();

    // limit one: display loads once every position has a char
    set_limit(4'd1);
    for (int k = 0; k < NAME_CHARS_DEF - 1; k++) send_char(POS_W'(k), CHAR_W'(8'h41 + k));
    send_char(4'd7, 8'hFF);
    send_char(4'd0, 8'h41);
    send_char(4'd0, 8'h5A);
    send_char(4'd0, 8'h5A);
    send_char(4'd8, 8'hFF);
    send_char(4'd15, 8'h00);
    send_char(4'd7, 8'h00);
    send_char(4'd7, 8'hFF);
    send_char(4'd7, 8'h00);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct  = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      if (p == 5) set_limit(CNT_W'($urandom_range(14, 1)));
      else set_limit(limits[p]);
      send_names(130);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
